### rtl/assert_macros.svh
// assertion macros shared by the checker files
// needs clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CIF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("can_idf assertion failed");

// next-cycle implication, disabled during reset
`define CIF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("can_idf assertion failed");

`endif

### rtl/can_idf_pkg.sv
// shared types, codes and helpers of the CAN id block filter
// no dependencies
package can_idf_pkg;

  localparam int unsigned TableEntriesDef = 10;
  localparam int unsigned IdW             = 11;
  localparam int unsigned DlcW            = 4;
  localparam int unsigned DataW           = 64;

  typedef enum logic [1:0] {
    FUNC_FRAME  = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_FORWARDED = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_DISABLED  = 3'd2,
    ST_ADDED     = 3'd3,
    ST_ALREADY   = 3'd4,
    ST_FULL      = 3'd5,
    ST_REMOVED   = 3'd6,
    ST_NOTFOUND  = 3'd7
  } status_t;

  // control from the sequencer to the table memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_valid;
  } tbl_ctl_t;

  // zero the data bytes past the length; long codes keep all eight bytes
  function automatic logic [DataW-1:0] keep_bytes(input logic [DataW-1:0] data,
                                                   input logic [DlcW-1:0]  dlc);
    logic [DataW-1:0] res;
    res = data;
    for (int b = 0; b < 8; b++) begin
      if (dlc < DlcW'(8) && DlcW'(b) >= dlc) begin
        res[b*8 +: 8] = 8'h00;
      end
    end
    return res;
  endfunction

endpackage

### rtl/can_idf_if.sv
// valid/ready channel interfaces for item input and result output
// depends on can_idf_pkg
interface can_idf_in_if
  import can_idf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [IdW-1:0]   can_id;
  logic [DlcW-1:0]  dlc;
  logic [DataW-1:0] payload;

  modport source (output valid, func, can_id, dlc, payload, input ready);
  modport sink   (input valid, func, can_id, dlc, payload, output ready);
endinterface

interface can_idf_out_if
  import can_idf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic             tx_valid;
  logic [IdW-1:0]   tx_id;
  logic [DlcW-1:0]  tx_dlc;
  logic [DataW-1:0] tx_payload;

  modport source (output valid, status, tx_valid, tx_id, tx_dlc, tx_payload, input ready);
  modport sink   (input valid, status, tx_valid, tx_id, tx_dlc, tx_payload, output ready);
endinterface

### rtl/can_id_block_filter_core.sv
// top level of the CAN id block filter: config register, sequencer, table
// depends on can_idf_pkg, can_idf_if, can_idf_table, can_idf_seq
//
//   channel   direction  handshake       contents
//   in_chan   sink       valid / ready   func, can_id, dlc, payload
//   out_chan  source     valid / ready   status, tx_valid, tx_id, tx_dlc, tx_payload
//   cfg       write      cfg_we          cfg_wdata = forward_enable
//
// frame, add and remove transactions scan the whole table over its single read
// port; func 3 is taken and dropped with no result.
// one transaction is in work at a time; the output register holds a finished
// result while the next transaction is taken and scanned.
// reset is synchronous and empties the table at once; forwarding starts disabled.
// a stalled output only holds the final update step, never the scan.
module can_id_block_filter_core
  import can_idf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  can_idf_in_if.sink    in_chan,
  can_idf_out_if.source out_chan
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic            fwd_en_r;
  tbl_ctl_t        tbl_ctl;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_addr;
  logic [IdW-1:0]  wr_id;
  logic [IdW-1:0]  rd_id;
  logic            rd_vld;

  // forward enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_en_r <= 1'b0;
    end else if (cfg_we) begin
      fwd_en_r <= cfg_wdata;
    end
  end

  can_idf_seq #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .fwd_en   (fwd_en_r),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .tbl_ctl  (tbl_ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_id    (wr_id),
    .rd_id    (rd_id),
    .rd_vld   (rd_vld)
  );

  can_idf_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tbl_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_id   (wr_id),
    .rd_id   (rd_id),
    .rd_vld  (rd_vld)
  );

endmodule

### rtl/can_idf_table.sv
// block table: id memory with registered read, per-slot valid flops
// depends on can_idf_pkg
module can_idf_table
  import can_idf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tbl_ctl_t            ctl,
  input  logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_addr,
  input  logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0] wr_addr,
  input  logic [IdW-1:0]      wr_id,
  output logic [IdW-1:0]      rd_id,
  output logic                rd_vld
);

  logic [IdW-1:0]           id_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [IdW-1:0]           rd_id_r;
  logic                     rd_vld_r;

  // id storage, only written when a slot is filled
  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.wr_valid) begin
      id_mem[wr_addr] <= wr_id;
    end
    if (ctl.rd_en) begin
      rd_id_r <= id_mem[rd_addr];
    end
  end

  // slot valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[wr_addr] <= ctl.wr_valid;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_id  = rd_id_r;
  assign rd_vld = rd_vld_r;

endmodule

### rtl/can_idf_seq.sv
// sequencer: takes a transaction, scans the table, updates it, registers the result
// depends on can_idf_pkg, can_idf_if
module can_idf_seq
  import can_idf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fwd_en,
  can_idf_in_if.sink          in_chan,
  can_idf_out_if.source       out_chan,
  output tbl_ctl_t            tbl_ctl,
  output logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_addr,
  output logic [(TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1)-1:0] wr_addr,
  output logic [IdW-1:0]      wr_id,
  input  logic [IdW-1:0]      rd_id,
  input  logic                rd_vld
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE
  } state_t;

  state_t           state_r;
  logic [1:0]       func_r;
  logic [IdW-1:0]   id_r;
  logic [DlcW-1:0]  dlc_r;
  logic [DataW-1:0] pay_r;
  logic [CntW-1:0]  rd_cnt_r;
  logic             cmp_vld_r;
  logic [IdxW-1:0]  cmp_idx_r;
  logic             hit_fnd_r;
  logic [IdxW-1:0]  hit_idx_r;
  logic             free_fnd_r;
  logic [IdxW-1:0]  free_idx_r;

  logic             out_vld_r;
  logic [2:0]       out_status_r;
  logic             out_txv_r;
  logic [IdW-1:0]   out_id_r;
  logic [DlcW-1:0]  out_dlc_r;
  logic [DataW-1:0] out_pay_r;

  logic             rd_issue;
  logic             entry_hit;
  logic             entry_free;
  logic             out_free;
  logic             load;
  status_t          res_status;
  logic             res_txv;
  logic             wr_req;
  logic             wr_set;
  logic [IdxW-1:0]  wr_idx;

  assign in_chan.ready = (state_r == S_IDLE);
  assign out_free      = !out_vld_r || out_chan.ready;
  assign load          = (state_r == S_RESOLVE) && out_free;

  // table read issue during the scan
  assign rd_issue = (state_r == S_SCAN) && (rd_cnt_r < CntW'(TABLE_ENTRIES));
  assign rd_addr  = rd_cnt_r[IdxW-1:0];

  // compare on the entry that came back from memory
  assign entry_hit  = cmp_vld_r && rd_vld && (rd_id == id_r);
  assign entry_free = cmp_vld_r && !rd_vld;

  // outcome of the operation once the scan is complete
  always_comb begin
    res_status = ST_NOTFOUND;
    res_txv    = 1'b0;
    wr_req     = 1'b0;
    wr_set     = 1'b0;
    wr_idx     = hit_idx_r;
    unique case (func_r)
      FUNC_FRAME: begin
        if (!fwd_en) begin
          res_status = ST_DISABLED;
        end else if (hit_fnd_r) begin
          res_status = ST_BLOCKED;
        end else begin
          res_status = ST_FORWARDED;
          res_txv    = 1'b1;
        end
      end
      FUNC_ADD: begin
        if (hit_fnd_r) begin
          res_status = ST_ALREADY;
        end else if (!free_fnd_r) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_ADDED;
          wr_req     = 1'b1;
          wr_set     = 1'b1;
          wr_idx     = free_idx_r;
        end
      end
      FUNC_REMOVE: begin
        if (hit_fnd_r) begin
          res_status = ST_REMOVED;
          wr_req     = 1'b1;
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      default: begin
        res_status = ST_NOTFOUND;
      end
    endcase
  end

  // table control toward the memory
  always_comb begin
    tbl_ctl.rd_en    = rd_issue;
    tbl_ctl.wr_en    = load && wr_req;
    tbl_ctl.wr_valid = wr_set;
  end
  assign wr_addr = wr_idx;
  assign wr_id   = id_r;

  // state, scan bookkeeping and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rd_cnt_r   <= '0;
      cmp_vld_r  <= 1'b0;
      hit_fnd_r  <= 1'b0;
      free_fnd_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (out_vld_r && out_chan.ready && !load) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid && func_t'(in_chan.func) != FUNC_NONE) begin
            func_r     <= in_chan.func;
            id_r       <= in_chan.can_id;
            dlc_r      <= in_chan.dlc;
            pay_r      <= in_chan.payload;
            rd_cnt_r   <= '0;
            cmp_vld_r  <= 1'b0;
            hit_fnd_r  <= 1'b0;
            free_fnd_r <= 1'b0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_vld_r <= rd_issue;
          cmp_idx_r <= rd_addr;
          if (rd_issue) begin
            rd_cnt_r <= rd_cnt_r + CntW'(1);
          end
          // first matching slot and lowest free slot
          if (entry_hit && !hit_fnd_r) begin
            hit_fnd_r <= 1'b1;
            hit_idx_r <= cmp_idx_r;
          end
          if (entry_free && !free_fnd_r) begin
            free_fnd_r <= 1'b1;
            free_idx_r <= cmp_idx_r;
          end
          if (cmp_vld_r && cmp_idx_r == LastIdx) begin
            state_r <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (out_free) begin
            out_vld_r    <= 1'b1;
            out_status_r <= res_status;
            out_txv_r    <= res_txv;
            out_id_r     <= res_txv ? id_r : '0;
            out_dlc_r    <= res_txv ? dlc_r : '0;
            out_pay_r    <= res_txv ? keep_bytes(pay_r, dlc_r) : '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.tx_valid   = out_txv_r;
  assign out_chan.tx_id      = out_id_r;
  assign out_chan.tx_dlc     = out_dlc_r;
  assign out_chan.tx_payload = out_pay_r;

endmodule

### rtl/can_idf_checker.sv
// port-level checks of the CAN id block filter, bound to the top level
// depends on can_idf_pkg and assert_macros.svh
`include "assert_macros.svh"

module can_idf_checker
  import can_idf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic       out_tx_valid
);

  // a stalled result keeps its status
  `CIF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status))

  // a sent frame always reports forwarded, and forwarded always sends
  `CIF_ASSERT_IMP(a_tx_fwd, out_valid && out_tx_valid, out_status == ST_FORWARDED)
  `CIF_ASSERT_IMP(a_fwd_tx, out_valid && out_status == ST_FORWARDED, out_tx_valid)

  // a table or frame transaction is followed by the scan, not by another take
  `CIF_ASSERT_NXT(a_busy, in_valid && in_ready && in_func != FUNC_NONE, !in_ready)

endmodule

bind can_id_block_filter_core can_idf_checker u_can_idf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_func      (in_chan.func),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_status   (out_chan.status),
  .out_tx_valid (out_chan.tx_valid)
);

### tb/tb_can_id_block_filter_core.sv
// self-checking testbench for the CAN id block filter core
// depends on can_idf_pkg, can_idf_if and can_id_block_filter_core
// a scoreboard class predicts every result; tasks drive items and forward_enable
`timescale 1ns / 100ps

module tb_can_id_block_filter_core;
  import can_idf_pkg::*;

  localparam int unsigned DRAIN_CYCLES = TableEntriesDef + 10;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned POOL_SIZE    = 16;
  localparam int unsigned PHASE_ITEMS  = 115;

  // one input transaction
  typedef struct packed {
    func_t            func;
    logic [IdW-1:0]   can_id;
    logic [DlcW-1:0]  dlc;
    logic [DataW-1:0] payload;
  } filter_item_t;

  // one result transaction
  typedef struct packed {
    status_t          status;
    logic             tx_valid;
    logic [IdW-1:0]   tx_id;
    logic [DlcW-1:0]  tx_dlc;
    logic [DataW-1:0] tx_payload;
  } filter_result_t;

  // block table model and queue of expected results
  class filter_scoreboard;
    logic [IdW-1:0] slot_id [TableEntriesDef];
    bit             slot_used [TableEntriesDef];
    bit             fwd_en;
    filter_result_t expected_q [$];
    int             err_cnt;
    int             checked_cnt;
    int             status_hits [8];

    function new();
      for (int i = 0; i < TableEntriesDef; i++) begin
        slot_id[i]   = '0;
        slot_used[i] = 1'b0;
      end
      fwd_en      = 1'b0;
      err_cnt     = 0;
      checked_cnt = 0;
      for (int s = 0; s < 8; s++) status_hits[s] = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int find_id(logic [IdW-1:0] id);
      int hit;
      hit = -1;
      for (int i = TableEntriesDef - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_id[i] == id) hit = i;
      end
      return hit;
    endfunction

    // work out the result of an accepted transaction and update the table
    function void note_input(filter_item_t it);
      filter_result_t r;
      int             hit;
      bit             placed;
      r      = '0;
      placed = 1'b0;
      if (it.func == FUNC_NONE) return;
      hit = find_id(it.can_id);
      case (it.func)
        FUNC_FRAME: begin
          if (!fwd_en) begin
            r.status = ST_DISABLED;
          end else if (hit >= 0) begin
            r.status = ST_BLOCKED;
          end else begin
            r.status   = ST_FORWARDED;
            r.tx_valid = 1'b1;
            r.tx_id    = it.can_id;
            r.tx_dlc   = it.dlc;
            // bytes past the length are cleared, long codes keep all eight
            if (it.dlc < 4'd8) begin
              r.tx_payload = it.payload & ((64'd1 << (8 * it.dlc)) - 64'd1);
            end else begin
              r.tx_payload = it.payload;
            end
          end
        end
        FUNC_ADD: begin
          if (hit >= 0) begin
            r.status = ST_ALREADY;
          end else begin
            r.status = ST_FULL;
            // lowest free slot takes the id
            for (int i = 0; i < TableEntriesDef; i++) begin
              if (!placed && !slot_used[i]) begin
                slot_used[i] = 1'b1;
                slot_id[i]   = it.can_id;
                r.status     = ST_ADDED;
                placed       = 1'b1;
              end
            end
          end
        end
        default: begin
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            slot_id[hit]   = '0;
            r.status       = ST_REMOVED;
          end else begin
            r.status = ST_NOTFOUND;
          end
        end
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
      err_cnt++;
      if (err_cnt <= 40) begin
        $display("%0t ns  result %0d: %s is %0h, wanted %0h",
                 $time, checked_cnt, what, got, want);
      end
    endtask

    // compare a result transaction with the oldest expectation
    task check_result(filter_result_t got);
      filter_result_t want;
      if (expected_q.size() == 0) begin
        report("result without expectation, status", DataW'(got.status), '0);
        return;
      end
      want = expected_q.pop_front();
      checked_cnt++;
      status_hits[want.status]++;
      if (got.status !== want.status)
        report("status", DataW'(got.status), DataW'(want.status));
      if (got.tx_valid !== want.tx_valid)
        report("tx_valid", DataW'(got.tx_valid), DataW'(want.tx_valid));
      if (got.tx_id !== want.tx_id)
        report("tx_id", DataW'(got.tx_id), DataW'(want.tx_id));
      if (got.tx_dlc !== want.tx_dlc)
        report("tx_dlc", DataW'(got.tx_dlc), DataW'(want.tx_dlc));
      if (got.tx_payload !== want.tx_payload)
        report("tx_payload", got.tx_payload, want.tx_payload);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  can_idf_in_if  in_chan ();
  can_idf_out_if out_chan ();

  can_id_block_filter_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  filter_scoreboard sb = new();

  int               cycle_cnt = 0;
  int               sent_cnt = 0;
  int               ignored_cnt = 0;
  int               cfg_writes = 0;
  int               burst_left = 0;
  bit               no_gaps = 1'b1;
  int               rx_tick = 0;
  int               rx_stall = 0;
  logic [IdW-1:0]   id_pool [POOL_SIZE];

  // clock, 12 ns period
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_can_id_block_filter_core: done, errors");
      $finish;
    end
  end

  // receiver stall pattern, changes character in turn among four modes
  always @(negedge clk) begin
    rx_tick++;
    case ((rx_tick / 256) % 4)
      0: out_chan.ready <= 1'b1;
      1: out_chan.ready <= ($urandom_range(0, 3) != 0);
      2: out_chan.ready <= (rx_tick % 5 == 0);
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          out_chan.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          rx_stall = $urandom_range(1, 20);
          out_chan.ready <= 1'b0;
        end else begin
          out_chan.ready <= 1'b1;
        end
      end
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    filter_result_t got;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got.status     = status_t'(out_chan.status);
      got.tx_valid   = out_chan.tx_valid;
      got.tx_id      = out_chan.tx_id;
      got.tx_dlc     = out_chan.tx_dlc;
      got.tx_payload = out_chan.tx_payload;
      sb.check_result(got);
    end
  end

  function automatic filter_item_t make_item(func_t f, logic [IdW-1:0] id,
                                             logic [DlcW-1:0] dlc,
                                             logic [DataW-1:0] payload);
    filter_item_t it;
    it.func    = f;
    it.can_id  = id;
    it.dlc     = dlc;
    it.payload = payload;
    return it;
  endfunction

  // random transaction, ids mostly from a small pool so the table sees hits
  function automatic filter_item_t random_item(int add_pct, int remove_pct);
    filter_item_t it;
    int           pick;
    pick = $urandom_range(0, 99);
    if (pick < 4)                           it.func = FUNC_NONE;
    else if (pick < 4 + add_pct)            it.func = FUNC_ADD;
    else if (pick < 4 + add_pct + remove_pct) it.func = FUNC_REMOVE;
    else                                    it.func = FUNC_FRAME;
    if ($urandom_range(0, 99) < 85) it.can_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    else                            it.can_id = IdW'($urandom_range(0, 2047));
    if ($urandom_range(0, 4) == 0) it.dlc = DlcW'($urandom_range(9, 15));
    else                           it.dlc = DlcW'($urandom_range(0, 8));
    it.payload = {$urandom(), $urandom()};
    return it;
  endfunction

  // send one transaction, with burst gaps in front unless gaps are off
  task automatic send_item(filter_item_t it);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      repeat (gap) begin
        @(negedge clk);
        in_chan.valid <= 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_chan.valid   <= 1'b1;
    in_chan.func    <= it.func;
    in_chan.can_id  <= it.can_id;
    in_chan.dlc     <= it.dlc;
    in_chan.payload <= it.payload;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    sb.note_input(it);
    if (it.func == FUNC_NONE) ignored_cnt++;
    else                      sent_cnt++;
  endtask

  // hold the sender until every expected result is back
  task automatic wait_drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // forward_enable is only written with the block idle
  task automatic set_forward(bit en);
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.fwd_en = en;
    cfg_writes++;
  endtask

  task automatic random_phase(int add_pct, int remove_pct);
    int done_cnt;
    filter_item_t it;
    done_cnt = 0;
    while (done_cnt < PHASE_ITEMS) begin
      it = random_item(add_pct, remove_pct);
      send_item(it);
      if (it.func != FUNC_NONE) done_cnt++;
    end
  endtask

  initial begin
    in_chan.valid   = 1'b0;
    in_chan.func    = '0;
    in_chan.can_id  = '0;
    in_chan.dlc     = '0;
    in_chan.payload = '0;
    out_chan.ready  = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    rst_n           = 1'b0;

    // pool holds zero, id 100, the top ids and a few random ones
    id_pool[0] = '0;
    id_pool[1] = IdW'(100);
    for (int i = 2; i < 11; i++) id_pool[i] = IdW'(2049 - i);
    for (int i = 11; i < POOL_SIZE; i++) id_pool[i] = IdW'($urandom_range(0, 2047));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: forwarding off after reset
    set_forward(1'b0);
    send_item(make_item(FUNC_FRAME, '0, 4'd0, {$urandom(), $urandom()}));
    send_item(make_item(FUNC_ADD, '0, 4'd0, '0));
    send_item(make_item(FUNC_FRAME, 11'h7ff, 4'd8, '1));

    // directed: forwarding on, length handling and table edge cases
    set_forward(1'b1);
    send_item(make_item(FUNC_FRAME, '0, 4'd8, '1));
    send_item(make_item(FUNC_FRAME, 11'h7ff, 4'd8, '1));
    send_item(make_item(FUNC_FRAME, 11'd5, 4'd15, {$urandom(), $urandom()}));
    send_item(make_item(FUNC_FRAME, 11'd6, 4'd3, '1));
    send_item(make_item(FUNC_ADD, '0, 4'd0, '0));
    for (int i = 1; i < TableEntriesDef; i++) begin
      send_item(make_item(FUNC_ADD, IdW'(2048 - i), 4'd0, '0));
    end
    send_item(make_item(FUNC_ADD, 11'd100, 4'd0, '0));
    send_item(make_item(FUNC_REMOVE, 11'd100, 4'd0, '0));
    send_item(make_item(FUNC_REMOVE, '0, 4'd0, '0));
    send_item(make_item(FUNC_NONE, '0, 4'hf, '1));
    send_item(make_item(FUNC_ADD, 11'd100, 4'd0, '0));
    send_item(make_item(FUNC_FRAME, 11'd100, 4'd2, '1));

    // random phases with sender gaps, but for one phase without
    no_gaps = 1'b0;
    random_phase(30, 15);
    set_forward(1'b0);
    random_phase(20, 20);
    set_forward(1'b1);
    random_phase(15, 30);
    no_gaps = 1'b1;
    random_phase(25, 25);
    wait_drain();
    no_gaps = 1'b0;
    random_phase(25, 25);

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report("results still missing", DataW'(sb.pending()), '0);

    $display("tb_can_id_block_filter_core: %0d transactions (%0d func 3), %0d results, %0d cfg writes",
             sent_cnt, ignored_cnt, sb.checked_cnt, cfg_writes);
    $display("  fwd %0d blk %0d dis %0d add %0d already %0d full %0d rem %0d notfound %0d",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2], sb.status_hits[3],
             sb.status_hits[4], sb.status_hits[5], sb.status_hits[6], sb.status_hits[7]);
    if (sb.err_cnt == 0) begin
      $display("tb_can_id_block_filter_core: done, clean");
    end else begin
      $display("tb_can_id_block_filter_core: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/can_idf_pkg.sv
rtl/can_idf_if.sv
rtl/can_idf_table.sv
rtl/can_idf_seq.sv
rtl/can_id_block_filter_core.sv
rtl/can_idf_checker.sv
tb/tb_can_id_block_filter_core.sv
